FILE: rtl/core/scbst_pkg.sv
package scbst_pkg;
    localparam int MAX_KEYS_DEF = 64;
    localparam int KEY_W = 32;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_MAP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;
endpackage

FILE: rtl/core/scbst_if.sv
interface scbst_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] key;
    logic        last;
    modport source (output valid, key, last, input ready);
    modport sink (input valid, key, last, output ready);
endinterface

interface scbst_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] key_res;
    logic        last_res;
    logic        dropped;
    modport source (output valid, key_res, last_res, dropped, input ready);
    modport sink (input valid, key_res, last_res, dropped, output ready);
endinterface

FILE: rtl/core/scbst_cell.sv
module scbst_cell
    import scbst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic              i_prev_full,
    input  logic signed [KEY_W-1:0] i_prev_key,
    input  logic              i_prev_take,
    input  logic              i_next_full,
    input  logic signed [KEY_W-1:0] i_next_key,
    output logic              o_full,
    output logic signed [KEY_W-1:0] o_key,
    output logic              o_take
);
    logic                    r_full;
    logic signed [KEY_W-1:0] r_key;

    // new key goes in this cell when the cell is empty or the key is smaller than the held key
    assign o_take = i_ctl.load && (!r_full || (i_key < r_key));
    assign o_full = r_full;
    assign o_key  = r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_ctl.load) begin
            if (i_prev_take) begin
                // left neighbor took the key, its old content moves right
                r_full <= i_prev_full;
                r_key  <= i_prev_key;
            end else if (o_take) begin
                r_full <= 1'b1;
                r_key  <= i_key;
            end
        end else if (i_ctl.shift) begin
            r_full <= i_next_full;
            r_key  <= i_next_key;
        end
    end
endmodule

FILE: rtl/core/scbst_map.sv
module scbst_map
    import scbst_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [$clog2(MAX_KEYS+1)-1:0] i_n,
    input  logic                     i_step,
    output logic                     o_done,
    output logic                     o_visit,
    output logic [$clog2(MAX_KEYS)-1:0]  o_node
);
    localparam int NW = $clog2(MAX_KEYS+1) + 1;
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int SD = $clog2(MAX_KEYS+1);

    // explicit in-order walk: stack of pending nodes, one visit per step
    logic [NW-1:0] r_stack [SD];
    logic [$clog2(SD+1)-1:0] r_sp;
    logic [NW-1:0] r_node;
    logic          r_desc;
    logic [NW-1:0] n_top;
    logic [NW-1:0] w_n;

    assign w_n     = NW'(i_n);
    assign n_top   = r_stack[r_sp - 1'b1];
    assign o_done  = !r_desc && (r_node > w_n) && (r_sp == '0);
    assign o_visit = !r_desc && (r_sp != '0);
    assign o_node  = AW'(n_top - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp   <= '0;
            r_node <= '0;
            r_desc <= 1'b0;
        end else if (i_start) begin
            r_sp   <= '0;
            r_node <= NW'(1);
            r_desc <= 1'b1;
        end else if (r_desc) begin
            // descend left, pushing nodes, one per cycle
            if (r_node <= w_n) begin
                r_stack[r_sp] <= r_node;
                r_sp          <= r_sp + 1'b1;
                r_node        <= {r_node[NW-2:0], 1'b0};
            end else begin
                r_desc <= 1'b0;
            end
        end else if (i_step && r_sp != '0) begin
            r_sp   <= r_sp - 1'b1;
            r_node <= {n_top[NW-2:0], 1'b1};
            r_desc <= 1'b1;
        end
    end
endmodule

FILE: rtl/core/sorted_complete_bst_layout_top.sv
// channel  | dir | payload                    | role
// s_in     | in  | key[31:0], last            | one key request per cycle while loading
// m_out    | out | key_res[31:0], last_res, dropped | one result per ready cycle
//
// loading takes one key per cycle: the cell chain inserts in sorted order
// at once, holding the row ascending from cell 0
// after last, the walk places sorted keys into the tree memory: for each
// key the in-order walk stack descends, then pops a node
// emitting then runs one result per ready cycle from the tree memory read port
// reset is synchronous, active low; it empties the chain and the counters
// a stall on the output holds the result register; no input is taken until
// the batch is emitted
module sorted_complete_bst_layout_top
    import scbst_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scbst_in_if.sink    s_in,
    scbst_out_if.source m_out
);
    localparam int CW = $clog2(MAX_KEYS+1);
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, r_emit;
    logic          r_ovf;
    t_cell_ctl     w_ctl;
    logic [MAX_KEYS:0]       w_full, w_take;
    logic signed [KEY_W-1:0] w_key [MAX_KEYS+1];
    logic signed [KEY_W-1:0] r_tree [MAX_KEYS];
    logic          w_acc, w_map_start, w_step, w_done, w_visit;
    logic [AW-1:0] w_node;
    logic          r_ov, r_ol, r_od;
    logic signed [KEY_W-1:0] r_ok;
    logic          w_emit_go, w_last_go;
    logic          r_started;

    assign w_acc = s_in.valid && s_in.ready;
    assign s_in.ready = (r_state == ST_LOAD);
    assign w_ctl.load  = w_acc && (r_cnt < CW'(MAX_KEYS));
    assign w_ctl.shift = w_step;

    // sentinel beyond the last cell
    assign w_full[MAX_KEYS] = 1'b0;
    assign w_key[MAX_KEYS]  = '0;
    assign w_take[MAX_KEYS] = 1'b0;

    for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
        logic pf, pt;
        logic signed [KEY_W-1:0] pk;
        if (g == 0) begin : g_first
            assign pf = 1'b0;
            assign pt = 1'b0;
            assign pk = '0;
        end else begin : g_rest
            assign pf = w_full[g-1];
            assign pt = w_take[g-1];
            assign pk = w_key[g-1];
        end
        scbst_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .i_key(s_in.key),
            .i_prev_full(pf), .i_prev_key(pk), .i_prev_take(pt),
            .i_next_full(w_full[g+1]), .i_next_key(w_key[g+1]),
            .o_full(w_full[g]), .o_key(w_key[g]), .o_take(w_take[g])
        );
    end

    assign w_map_start = (r_state == ST_DRAIN);
    scbst_map #(.MAX_KEYS(MAX_KEYS)) u_map (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_map_start), .i_n(r_cnt),
        .i_step(w_step), .o_done(w_done), .o_visit(w_visit), .o_node(w_node)
    );

    // a visit is ready when the walk is not descending and has a pending node
    always_comb begin
        w_step = 1'b0;
        if (r_state == ST_MAP && r_started && !w_done) w_step = w_visit;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:  if (w_acc && s_in.last) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_MAP;
            ST_MAP:   if (r_started && w_done) n_state = ST_EMIT;
            ST_EMIT:  if (w_last_go) n_state = ST_LOAD;
            default:  n_state = ST_LOAD;
        endcase
    end

    assign w_emit_go = (r_state == ST_EMIT) && (!r_ov || m_out.ready) && (r_emit < r_cnt);
    assign w_last_go = r_ov && m_out.ready && r_ol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_emit    <= '0;
            r_ov      <= 1'b0;
            r_started <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_acc) begin
                if (r_cnt < CW'(MAX_KEYS)) r_cnt <= r_cnt + 1'b1;
                else r_ovf <= 1'b1;
            end
            r_started <= (r_state == ST_MAP);
            if (r_state == ST_DRAIN) begin
                r_emit <= '0;
            end
            if (w_emit_go) begin
                r_ov   <= 1'b1;
                r_emit <= r_emit + 1'b1;
            end else if (m_out.ready) begin
                r_ov <= 1'b0;
            end
            if (w_last_go) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end
        end
    end

    // tree memory: written in walk order, read in level order
    always_ff @(posedge i_clk) begin
        if (w_step) r_tree[w_node] <= w_key[0];
        if (w_emit_go) begin
            r_ok <= r_tree[AW'(r_emit)];
            r_ol <= (r_emit + 1'b1 == r_cnt);
            r_od <= r_ovf;
        end
    end

    assign m_out.valid    = r_ov;
    assign m_out.key_res  = r_ok;
    assign m_out.last_res = r_ol;
    assign m_out.dropped  = r_od;
endmodule
